/* rtl/core/ssba_pkg.sv */
// shared types, constants and helper functions of the slab slot bitmap allocator
package ssba_pkg;

  localparam int unsigned MapWords = 8;
  localparam int unsigned WordBits = 64;
  localparam int unsigned BitAw    = $clog2(WordBits);
  localparam int unsigned WordAw   = (MapWords > 1) ? $clog2(MapWords) : 1;
  localparam int unsigned WordsW   = $clog2(MapWords + 1);
  localparam int unsigned SlotW    = 9;
  localparam int unsigned CountW   = 10;
  localparam int unsigned MaxSlots = 512;
  localparam int unsigned CapSlots =
      (MaxSlots > MapWords * WordBits) ? MapWords * WordBits : MaxSlots;

  typedef logic [WordBits-1:0] word_t;
  typedef logic [WordAw-1:0]   waddr_t;
  typedef logic [WordsW-1:0]   wcount_t;
  typedef logic [CountW-1:0]   count_t;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_INIT  = 2'd2,
    OP_RSVD  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NONE   = 2'd1,
    ST_DOUBLE = 2'd2,
    ST_RANGE  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ALLOC_WR,
    S_FREE_CHK,
    S_INIT_WR
  } state_e;

  // one access to the free map memory
  typedef struct packed {
    logic   rd_en;
    logic   wr_en;
    waddr_t addr;
    word_t  wdata;
  } map_req_t;

  // isolate the lowest set bit
  function automatic word_t lowest_onehot(word_t v);
    return v & (~v + word_t'(1));
  endfunction

  // bit position of a one-hot word
  function automatic logic [BitAw-1:0] onehot_pos(word_t oh);
    logic [BitAw-1:0] pos;
    pos = '0;
    for (int i = 0; i < WordBits; i++) begin
      pos = pos | (oh[i] ? BitAw'(i) : '0);
    end
    return pos;
  endfunction

  // hint modulo the number of words in use (narrow, bounded steps)
  function automatic waddr_t wrap_hint(waddr_t hint, wcount_t words);
    wcount_t r;
    r = wcount_t'(hint);
    for (int i = 0; i < MapWords; i++) begin
      if (r >= words) begin
        r = r - words;
      end
    end
    return waddr_t'(r);
  endfunction

endpackage

/* rtl/core/slab_slot_bitmap_allocator.sv */
// top level of the slab slot bitmap allocator: size register, sequencer and free map
//
// One command at a time: start is taken when busy is low, and each command
// gives exactly one result, shown for a single cycle with done_o in the
// first cycle after busy drops; the receiver cannot stall it, and a new
// command may be started in the cycle the result is shown. The free map sits
// in an 8-word by 64-bit memory with one registered read port, so allocate
// reads one word per cycle, checks each word while reading the next, and
// writes back the first word examined that holds a free slot, or ends with
// no slot when none of the words in use has one. An in-range free reads the
// slot's word and sets its bit unless already free; an out-of-range free or
// the unused op code 3 answers without raising busy, and init sweeps all 8
// words. slots_in_slab is written through the cfg channel while idle; send
// init afterwards.
module slab_slot_bitmap_allocator (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [9:0] cfg_data_i,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] op_i,
  input  logic [8:0] slot_index_i,
  output logic       done_o,
  output logic [1:0] status_o,
  output logic [8:0] granted_slot_o,
  output logic [9:0] free_slots_o,
  output logic       became_full_o,
  output logic       became_partial_o,
  output logic       became_empty_o
);
  import ssba_pkg::*;

  count_t   slots_q;
  count_t   eff_slots;
  map_req_t map_req;
  word_t    map_rdata;

  // slab size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q <= count_t'(512);
    end else if (cfg_valid_i && cfg_ready_o) begin
      slots_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = ~busy;

  // clamp the size to 1..capacity
  always_comb begin
    if (slots_q == '0) begin
      eff_slots = count_t'(1);
    end else if (slots_q > count_t'(CapSlots)) begin
      eff_slots = count_t'(CapSlots);
    end else begin
      eff_slots = slots_q;
    end
  end

  ssba_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .op_i            (op_i),
    .slot_index_i    (slot_index_i),
    .eff_slots_i     (eff_slots),
    .map_req_o       (map_req),
    .map_rdata_i     (map_rdata),
    .done_o          (done_o),
    .status_o        (status_o),
    .granted_slot_o  (granted_slot_o),
    .free_slots_o    (free_slots_o),
    .became_full_o   (became_full_o),
    .became_partial_o(became_partial_o),
    .became_empty_o  (became_empty_o)
  );

  ssba_map u_map (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (map_req),
    .rdata_o(map_rdata)
  );

endmodule

/* rtl/core/ssba_ram.sv */
// generic single-clock ram with one write port and one registered read port
module ssba_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 8
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/ssba_map.sv */
// free map storage: ram plus per-word valid bits so unwritten words read as all free
module ssba_map (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ssba_pkg::map_req_t req_i,
  output ssba_pkg::word_t    rdata_o
);
  import ssba_pkg::*;

  logic [MapWords-1:0] valid_q;
  logic                rd_valid_q;
  word_t               ram_rdata;

  ssba_ram #(
    .Width(WordBits),
    .Depth(MapWords)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (req_i.wr_en),
    .waddr_i(req_i.addr),
    .wdata_i(req_i.wdata),
    .re_i   (req_i.rd_en),
    .raddr_i(req_i.addr),
    .rdata_o(ram_rdata)
  );

  // words not yet written hold the reset value of all free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        valid_q[req_i.addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_valid_q <= valid_q[req_i.addr];
      end
    end
  end

  assign rdata_o = rd_valid_q ? ram_rdata : '1;

endmodule

/* rtl/core/ssba_ctrl.sv */
// sequencer: scans, checks and rewrites free map words and keeps count and hint
module ssba_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             op_i,
  input  logic [8:0]             slot_index_i,
  input  ssba_pkg::count_t       eff_slots_i,
  output ssba_pkg::map_req_t     map_req_o,
  input  ssba_pkg::word_t        map_rdata_i,
  output logic                   done_o,
  output logic [1:0]             status_o,
  output logic [8:0]             granted_slot_o,
  output logic [9:0]             free_slots_o,
  output logic                   became_full_o,
  output logic                   became_partial_o,
  output logic                   became_empty_o
);
  import ssba_pkg::*;

  state_e  state_q, state_d;
  waddr_t  cur_w_q, cur_w_d;
  wcount_t iss_q, iss_d;
  logic    pend_q, pend_d;
  waddr_t  chk_w_q, chk_w_d;
  word_t   hit_word_q, hit_word_d;
  word_t   hit_oh_q, hit_oh_d;
  waddr_t  hit_w_q, hit_w_d;
  waddr_t  hint_q, hint_d;
  count_t  total_q, total_d;
  logic [SlotW-1:0] idx_q, idx_d;
  waddr_t  init_w_q, init_w_d;

  logic    done_q, done_d;
  status_e status_q, status_d;
  logic [SlotW-1:0] granted_q, granted_d;
  logic    full_q, full_d;
  logic    partial_q, partial_d;
  logic    empty_q, empty_d;

  wcount_t words;
  logic [CountW:0] words_sum;
  logic [BitAw-1:0] tail;
  word_t   tail_mask;
  word_t   init_word;
  word_t   free_mask;
  count_t  total_inc;
  count_t  total_dec;
  logic    hit;
  logic    issue;

  // words covered by the slab and the partial tail word
  assign words_sum = {1'b0, eff_slots_i} + (CountW + 1)'(WordBits - 1);
  assign words     = words_sum[BitAw +: WordsW];
  assign tail      = eff_slots_i[BitAw-1:0];
  assign tail_mask = ~({WordBits{1'b1}} << tail);

  // init value of the word being swept
  always_comb begin
    if ({1'b0, init_w_q} >= words) begin
      init_word = '0;
    end else if ((tail != '0) && ({1'b0, init_w_q} == words - wcount_t'(1))) begin
      init_word = tail_mask;
    end else begin
      init_word = '1;
    end
  end

  assign free_mask = word_t'(1) << idx_q[BitAw-1:0];
  assign total_inc = total_q + count_t'(1);
  assign total_dec = (total_q != '0) ? total_q - count_t'(1) : total_q;
  assign hit       = pend_q && (map_rdata_i != '0);
  assign issue     = (iss_q < words);

  // state and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      hint_q   <= '0;
      total_q  <= count_t'(MapWords * WordBits);
      done_q   <= 1'b0;
      pend_q   <= 1'b0;
      iss_q    <= '0;
      cur_w_q  <= '0;
      init_w_q <= '0;
    end else begin
      state_q  <= state_d;
      hint_q   <= hint_d;
      total_q  <= total_d;
      done_q   <= done_d;
      pend_q   <= pend_d;
      iss_q    <= iss_d;
      cur_w_q  <= cur_w_d;
      init_w_q <= init_w_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    chk_w_q    <= chk_w_d;
    hit_word_q <= hit_word_d;
    hit_oh_q   <= hit_oh_d;
    hit_w_q    <= hit_w_d;
    idx_q      <= idx_d;
    status_q   <= status_d;
    granted_q  <= granted_d;
    full_q     <= full_d;
    partial_q  <= partial_d;
    empty_q    <= empty_d;
  end

  // next state and memory access
  always_comb begin
    state_d    = state_q;
    cur_w_d    = cur_w_q;
    iss_d      = iss_q;
    pend_d     = pend_q;
    chk_w_d    = chk_w_q;
    hit_word_d = hit_word_q;
    hit_oh_d   = hit_oh_q;
    hit_w_d    = hit_w_q;
    hint_d     = hint_q;
    total_d    = total_q;
    idx_d      = idx_q;
    init_w_d   = init_w_q;
    done_d     = 1'b0;
    status_d   = status_q;
    granted_d  = granted_q;
    full_d     = full_q;
    partial_d  = partial_q;
    empty_d    = empty_q;
    map_req_o  = '0;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          status_d  = ST_OK;
          granted_d = '0;
          full_d    = 1'b0;
          partial_d = 1'b0;
          empty_d   = 1'b0;
          case (op_e'(op_i))
            OP_ALLOC: begin
              cur_w_d = wrap_hint(hint_q, words);
              iss_d   = '0;
              pend_d  = 1'b0;
              state_d = S_SCAN;
            end
            OP_FREE: begin
              idx_d = slot_index_i;
              if ({1'b0, slot_index_i} >= eff_slots_i) begin
                status_d = ST_RANGE;
                done_d   = 1'b1;
              end else begin
                map_req_o.rd_en = 1'b1;
                map_req_o.addr  = slot_index_i[SlotW-1:BitAw];
                state_d         = S_FREE_CHK;
              end
            end
            OP_INIT: begin
              init_w_d = '0;
              state_d  = S_INIT_WR;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      // one word read per cycle, the previous word checked alongside
      S_SCAN: begin
        if (hit) begin
          hit_word_d = map_rdata_i;
          hit_oh_d   = lowest_onehot(map_rdata_i);
          hit_w_d    = chk_w_q;
          pend_d     = 1'b0;
          state_d    = S_ALLOC_WR;
        end else if (issue) begin
          map_req_o.rd_en = 1'b1;
          map_req_o.addr  = cur_w_q;
          chk_w_d         = cur_w_q;
          pend_d          = 1'b1;
          iss_d           = iss_q + wcount_t'(1);
          cur_w_d         = ({1'b0, cur_w_q} == words - wcount_t'(1)) ?
                            '0 : cur_w_q + waddr_t'(1);
        end else begin
          pend_d   = 1'b0;
          status_d = ST_NONE;
          done_d   = 1'b1;
          state_d  = S_IDLE;
        end
      end

      // clear the granted bit
      S_ALLOC_WR: begin
        map_req_o.wr_en = 1'b1;
        map_req_o.addr  = hit_w_q;
        map_req_o.wdata = hit_word_q & ~hit_oh_q;
        total_d         = total_dec;
        full_d          = (total_dec == '0);
        hint_d          = hit_w_q;
        granted_d       = {hit_w_q, onehot_pos(hit_oh_q)};
        done_d          = 1'b1;
        state_d         = S_IDLE;
      end

      // reject a double free, else set the bit
      S_FREE_CHK: begin
        if ((map_rdata_i & free_mask) != '0) begin
          status_d = ST_DOUBLE;
        end else begin
          map_req_o.wr_en = 1'b1;
          map_req_o.addr  = idx_q[SlotW-1:BitAw];
          map_req_o.wdata = map_rdata_i | free_mask;
          total_d         = total_inc;
          partial_d       = (total_inc == count_t'(1));
          empty_d         = (total_inc == eff_slots_i);
        end
        done_d  = 1'b1;
        state_d = S_IDLE;
      end

      // sweep every word of the map
      S_INIT_WR: begin
        map_req_o.wr_en = 1'b1;
        map_req_o.addr  = init_w_q;
        map_req_o.wdata = init_word;
        if (init_w_q == waddr_t'(MapWords - 1)) begin
          total_d = eff_slots_i;
          hint_d  = '0;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          init_w_d = init_w_q + waddr_t'(1);
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy             = (state_q != S_IDLE);
  assign done_o           = done_q;
  assign status_o         = status_q;
  assign granted_slot_o   = granted_q;
  assign free_slots_o     = total_q;
  assign became_full_o    = full_q;
  assign became_partial_o = partial_q;
  assign became_empty_o   = empty_q;

  // map is only written by the states that modify it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    map_req_o.wr_en |-> (state_q == S_ALLOC_WR || state_q == S_FREE_CHK ||
                         state_q == S_INIT_WR))
    else $error("map written outside a write state");

  // a result is only shown once the sequencer is back in idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy)
    else $error("result strobe while busy");

  // a full slab is reported only with a zero count after a good allocate
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && full_q) |-> (total_q == '0 && status_q == ST_OK))
    else $error("full flag without an empty count");

  // failed items carry no slot and no flags
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && status_q != ST_OK) |->
      (granted_q == '0 && !full_q && !partial_q && !empty_q))
    else $error("failed item reports a slot or a flag");

endmodule
